[rtl/core/lapedge_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lapedge_pkg
// Shared widths, register indexes and the front-to-back queue entry of the
// 3x3 Laplacian edge detector.
// ----------------------------------------------------------------------------
package lapedge_pkg;

  localparam int LUMA_W  = 8;
  localparam int COORD_W = 10;
  localparam int SCORE_W = 12;
  localparam int CFG_W   = 11;
  localparam int SUM_W   = 11;

  // Configuration register indexes
  typedef logic [0:0] cfg_index_t;
  localparam cfg_index_t CFG_IMAGE_WIDTH    = 1'b0;
  localparam cfg_index_t CFG_EDGE_THRESHOLD = 1'b1;

  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST    = 11'd640;
  localparam logic [CFG_W-1:0] EDGE_THRESHOLD_RST = 11'd76;

  // Front-to-back queue
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [LUMA_W-1:0]  luma;
    logic [LUMA_W-1:0]  top;
    logic [LUMA_W-1:0]  mid;
    logic               judge;
    logic [COORD_W-1:0] centre_col;
    logic [COORD_W-1:0] centre_row;
  } q_entry_t;

endpackage

[rtl/core/lapedge_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lapedge_ram
// Generic single-write, single-read RAM with registered, read-first output.
// ----------------------------------------------------------------------------
module lapedge_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

[rtl/core/lapedge_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lapedge_front
// Pixel intake: raster position counters, line store access and
// classification of each pixel as window-complete or border.
// ----------------------------------------------------------------------------
module lapedge_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lapedge_pkg::LUMA_W-1:0] luma,
  input  logic                          frame_start,
  input  logic [lapedge_pkg::CFG_W-1:0]  image_width,
  output logic                          q_valid,
  input  logic                          q_ready,
  output lapedge_pkg::q_entry_t         q_entry
);
  import lapedge_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WW  = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int CPW = (CW > COORD_W) ? CW : COORD_W;
  localparam int RPW = (RW > COORD_W) ? RW : COORD_W;
  localparam int LW  = 2 * LUMA_W;

  logic [CW-1:0]      col_r, col_nxt, cur_col;
  logic [RW-1:0]      row_r, row_nxt, cur_row;
  logic [CW:0]        col_inc;
  logic [WW-1:0]      iw_ext, eff_w;
  logic               wrap;
  logic               accept, push, judge;
  logic               s1_valid_r, s1_valid_nxt;
  logic [LUMA_W-1:0]  s1_luma_r;
  logic [CW-1:0]      s1_col_r;
  logic               s1_judge_r;
  logic [COORD_W-1:0] s1_ccol_r, s1_crow_r;
  logic [CPW-1:0]     ccol_w;
  logic [RPW-1:0]     crow_w;
  logic [LW-1:0]      ram_rdata, line, wdata;
  logic               byp_r, byp_nxt;
  logic [LW-1:0]      byp_data_r;

  assign accept   = in_valid && in_ready;
  assign push     = s1_valid_r && q_ready;
  assign in_ready = !s1_valid_r || q_ready;

  // Frame start restarts placement at the origin
  assign cur_col = frame_start ? '0 : col_r;
  assign cur_row = frame_start ? '0 : row_r;

  // Clamp the programmed width to the supported range
  always_comb begin
    iw_ext = WW'(image_width);
    eff_w  = iw_ext;
    if (iw_ext < WW'(3)) begin
      eff_w = WW'(3);
    end else if (iw_ext > WW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end
  end

  assign col_inc = {1'b0, cur_col} + (CW+1)'(1);
  assign wrap    = WW'(col_inc) >= eff_w;
  assign judge   = (cur_col >= CW'(2)) && (cur_row >= RW'(2));
  assign ccol_w  = CPW'(cur_col) - CPW'(1);
  assign crow_w  = RPW'(cur_row) - RPW'(1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      col_nxt = wrap ? '0 : col_inc[CW-1:0];
      row_nxt = cur_row;
      if (wrap && (cur_row != RW'(MAX_HEIGHT - 1))) begin
        row_nxt = cur_row + RW'(1);
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (push) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Upper line in the high byte, middle line in the low byte
  assign line  = byp_r ? byp_data_r : ram_rdata;
  assign wdata = {line[LUMA_W-1:0], s1_luma_r};

  // Same-address write and read in one cycle: forward the written value
  assign byp_nxt = accept ? (push && (cur_col == s1_col_r)) : byp_r;

  lapedge_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (push),
    .waddr (s1_col_r),
    .wdata (wdata),
    .re    (accept),
    .raddr (cur_col),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
      byp_r      <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= s1_valid_nxt;
      byp_r      <= byp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_luma_r  <= luma;
      s1_col_r   <= cur_col;
      s1_judge_r <= judge;
      s1_ccol_r  <= ccol_w[COORD_W-1:0];
      s1_crow_r  <= crow_w[COORD_W-1:0];
      byp_data_r <= wdata;
    end
  end

  assign q_valid            = s1_valid_r;
  assign q_entry.luma       = s1_luma_r;
  assign q_entry.top        = line[LW-1:LUMA_W];
  assign q_entry.mid        = line[LUMA_W-1:0];
  assign q_entry.judge      = s1_judge_r;
  assign q_entry.centre_col = s1_ccol_r;
  assign q_entry.centre_row = s1_crow_r;

`ifndef SYNTHESIS
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("accepted pixel did not reach the line store stage");
`endif

endmodule

[rtl/core/lapedge_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lapedge_queue
// Short register FIFO that decouples pixel intake from window arithmetic.
// ----------------------------------------------------------------------------
module lapedge_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  lapedge_pkg::q_entry_t push_data,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output lapedge_pkg::q_entry_t pop_data
);
  import lapedge_pkg::*;

  q_entry_t         mem_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]  count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = count_r != Q_CW'(Q_DEPTH);
  assign pop_valid  = count_r != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + Q_CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - Q_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CW'(Q_DEPTH))
    else $error("queue fill count beyond depth");
`endif

endmodule

[rtl/core/lapedge_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lapedge_back
// 3x3 window shift, Laplacian score, threshold compare and result register.
// ----------------------------------------------------------------------------
module lapedge_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            pop_valid,
  output logic                            pop_ready,
  input  lapedge_pkg::q_entry_t           pop_data,
  input  logic [lapedge_pkg::CFG_W-1:0]   edge_threshold,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_edge,
  output logic [lapedge_pkg::SCORE_W-1:0] out_score,
  output logic [lapedge_pkg::COORD_W-1:0] out_col,
  output logic [lapedge_pkg::COORD_W-1:0] out_row
);
  import lapedge_pkg::*;

  // Window columns: [0..2] oldest column top/mid/bottom, [3..5] newer column
  logic [LUMA_W-1:0]  win_r [6];
  logic [SUM_W-1:0]   neigh;
  logic [SCORE_W-1:0] score_c;
  logic               do_pop, b1_adv, b2_free;
  logic               b1_valid_r, b1_valid_nxt;
  logic [SCORE_W-1:0] b1_score_r;
  logic [COORD_W-1:0] b1_col_r, b1_row_r;
  logic               out_valid_r, out_valid_nxt;
  logic               out_edge_r;
  logic [SCORE_W-1:0] out_score_r;
  logic [COORD_W-1:0] out_col_r, out_row_r;

  assign b2_free   = !out_valid_r || out_ready;
  assign b1_adv    = b1_valid_r && b2_free;
  assign pop_ready = !b1_valid_r || b2_free;
  assign do_pop    = pop_valid && pop_ready;

  assign neigh = SUM_W'(win_r[0]) + SUM_W'(win_r[1]) + SUM_W'(win_r[2])
               + SUM_W'(win_r[3]) + SUM_W'(win_r[5])
               + SUM_W'(pop_data.top) + SUM_W'(pop_data.mid) + SUM_W'(pop_data.luma);
  assign score_c = {1'b0, win_r[4], 3'b000} - SCORE_W'(neigh);

  always_comb begin
    b1_valid_nxt = b1_valid_r;
    if (do_pop) begin
      b1_valid_nxt = pop_data.judge;
    end else if (b1_adv) begin
      b1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (b1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      b1_valid_r  <= b1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Shift the window on every pixel, judged or not
  always_ff @(posedge clk) begin
    if (do_pop) begin
      win_r[0]   <= win_r[3];
      win_r[1]   <= win_r[4];
      win_r[2]   <= win_r[5];
      win_r[3]   <= pop_data.top;
      win_r[4]   <= pop_data.mid;
      win_r[5]   <= pop_data.luma;
      b1_score_r <= score_c;
      b1_col_r   <= pop_data.centre_col;
      b1_row_r   <= pop_data.centre_row;
    end
    if (b1_adv) begin
      out_edge_r  <= $signed(b1_score_r) > $signed({1'b0, edge_threshold});
      out_score_r <= b1_score_r;
      out_col_r   <= b1_col_r;
      out_row_r   <= b1_row_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_edge  = out_edge_r;
  assign out_score = out_score_r;
  assign out_col   = out_col_r;
  assign out_row   = out_row_r;

`ifndef SYNTHESIS
  a_edge_positive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_edge_r) |-> !out_score_r[SCORE_W-1])
    else $error("edge flagged on a negative score");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_score_r)
                                     && $stable(out_edge_r)))
    else $error("stalled result changed");
`endif

endmodule

[rtl/core/laplacian_edge_threshold_3x3.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laplacian_edge_threshold_3x3
// Streaming 3x3 Laplacian edge detector over raster-order 8-bit luma.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one pixel per beat, luma in in_tdata[7:0], in_tuser high on the
//           first pixel of a frame (restarts column and row at zero).
//   out_* : one beat per interior centre pixel, emitted once the pixel below
//           and right of the centre has been taken; border pixels give none.
//   cfg_* : register writes, always ready; write only while the block idles.
//           Index 0 is image width (clamped to 3..MAX_WIDTH), index 1 the
//           edge threshold (edge when score > threshold, signed compare).
// Throughput: one pixel per cycle sustained while out_tready stays high; the line store
//   is a 16-bit RAM with one read and one write port, each used once per pixel.
// Path: a completing pixel passes the intake stage, the queue, the score and result registers.
// Reset: counters and handshake state clear; line stores are not cleared.
// Stall: a held result keeps out_tdata/out_tuser stable; the window stage,
//   a two-entry queue and the intake stage fill before in_tready drops.
// ----------------------------------------------------------------------------
module laplacian_edge_threshold_3x3 #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Pixel input
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] luma
  input  logic                          in_tuser,   // [0] frame_start
  // Result output
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [31:0]                   out_tdata,  // [11:0] score, [21:12] centre_col,
                                                    // [31:22] centre_row
  output logic                          out_tuser,  // [0] edge_res
  // Configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  lapedge_pkg::cfg_index_t       cfg_index,
  input  logic [lapedge_pkg::CFG_W-1:0] cfg_data
);
  import lapedge_pkg::*;

  logic [CFG_W-1:0]   image_width_r, image_width_nxt;
  logic [CFG_W-1:0]   threshold_r, threshold_nxt;
  logic               q_in_valid, q_in_ready, q_out_valid, q_out_ready;
  q_entry_t           q_in_data, q_out_data;
  logic               res_edge;
  logic [SCORE_W-1:0] res_score;
  logic [COORD_W-1:0] res_col, res_row;

  // Always take configuration writes
  assign cfg_ready = 1'b1;

  always_comb begin
    image_width_nxt = image_width_r;
    threshold_nxt   = threshold_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:    image_width_nxt = cfg_data;
        CFG_EDGE_THRESHOLD: threshold_nxt   = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r <= IMAGE_WIDTH_RST;
      threshold_r   <= EDGE_THRESHOLD_RST;
    end else begin
      image_width_r <= image_width_nxt;
      threshold_r   <= threshold_nxt;
    end
  end

  // Intake: counters and line store
  lapedge_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .luma        (in_tdata),
    .frame_start (in_tuser),
    .image_width (image_width_r),
    .q_valid     (q_in_valid),
    .q_ready     (q_in_ready),
    .q_entry     (q_in_data)
  );

  // Decouple intake from the arithmetic
  lapedge_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_in_valid),
    .push_ready (q_in_ready),
    .push_data  (q_in_data),
    .pop_valid  (q_out_valid),
    .pop_ready  (q_out_ready),
    .pop_data   (q_out_data)
  );

  // Window, score and result register
  lapedge_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_valid      (q_out_valid),
    .pop_ready      (q_out_ready),
    .pop_data       (q_out_data),
    .edge_threshold (threshold_r),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_edge       (res_edge),
    .out_score      (res_score),
    .out_col        (res_col),
    .out_row        (res_row)
  );

  assign out_tdata = {res_row, res_col, res_score};
  assign out_tuser = res_edge;

endmodule
